@@ src/ubxff_pkg.sv @@
// Shared types, constants and helpers for the UBX frame filter.
// Used by ubxff_parser and ubx_frame_filter; depends on nothing else.
package ubxff_pkg;

  localparam logic [7:0] SYNC_FIRST  = 8'hB5;
  localparam logic [7:0] SYNC_SECOND = 8'h62;

  localparam int NUM_PAIRS = 5;

  localparam logic [7:0] PAIR_CLASS [NUM_PAIRS] = '{8'h01, 8'h01, 8'h02, 8'h01, 8'h02};
  localparam logic [7:0] PAIR_IDENT [NUM_PAIRS] = '{8'h02, 8'h21, 8'h10, 8'h20, 8'h15};

  localparam logic [15:0] MAX_LENGTH_RESET  = 16'd1024;
  localparam logic [4:0]  ACCEPT_MASK_RESET = 5'd31;

  typedef enum logic [0:0] {
    REG_MAX_LENGTH  = 1'b0,
    REG_ACCEPT_MASK = 1'b1
  } cfg_index_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_VALID   = 2'd1,
    KIND_BAD     = 2'd2
  } kind_t;

  typedef enum logic [8:0] {
    PH_HUNT    = 9'b000000001,
    PH_SYNC2   = 9'b000000010,
    PH_CLASS   = 9'b000000100,
    PH_IDENT   = 9'b000001000,
    PH_LEN_LO  = 9'b000010000,
    PH_LEN_HI  = 9'b000100000,
    PH_PAYLOAD = 9'b001000000,
    PH_CK_A    = 9'b010000000,
    PH_CK_B    = 9'b100000000
  } phase_t;

  typedef struct packed {
    logic [15:0] max_length;
    logic [4:0]  accept_mask;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  msg_class;
    logic [7:0]  msg_ident;
    logic [15:0] byte_offset;
    logic [7:0]  payload_byte;
    logic [15:0] frame_length;
  } result_t;

  function automatic logic pair_enabled(input logic [4:0] mask, input logic [7:0] cls,
                                        input logic [7:0] ident);
    logic hit;
    hit = 1'b0;
    for (int k = 0; k < NUM_PAIRS; k++) begin
      if (mask[k] && PAIR_CLASS[k] == cls && PAIR_IDENT[k] == ident) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

endpackage

@@ src/ubxff_parser.sv @@
// Frame parser: sync hunt, header decode, Fletcher sums and verdict.
// Depends on ubxff_pkg; instantiated by ubx_frame_filter.
module ubxff_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        rx_byte,
  input  ubxff_pkg::cfg_t   cfg,
  output logic              emit,
  output ubxff_pkg::result_t result
);

  ubxff_pkg::phase_t phase, phase_next;
  logic [7:0]  cur_class, cur_class_next;
  logic [7:0]  cur_ident, cur_ident_next;
  logic [15:0] announced_length, announced_length_next;
  logic [15:0] payload_count, payload_count_next;
  logic [7:0]  sum_a, sum_a_next;
  logic [7:0]  sum_b, sum_b_next;
  logic [7:0]  got_check_a, got_check_a_next;

  logic [7:0]  add_a;
  logic [7:0]  add_b;
  logic [15:0] length_full;
  logic [15:0] count_inc;

  assign add_a       = sum_a + rx_byte;
  assign add_b       = sum_b + add_a;
  assign length_full = {rx_byte, announced_length[7:0]};
  assign count_inc   = payload_count + 16'd1;

  always_comb begin
    phase_next            = phase;
    cur_class_next        = cur_class;
    cur_ident_next        = cur_ident;
    announced_length_next = announced_length;
    payload_count_next    = payload_count;
    sum_a_next            = sum_a;
    sum_b_next            = sum_b;
    got_check_a_next      = got_check_a;
    emit                  = 1'b0;
    result.kind           = ubxff_pkg::KIND_PAYLOAD;
    result.msg_class      = cur_class;
    result.msg_ident      = cur_ident;
    result.byte_offset    = 16'd0;
    result.payload_byte   = 8'd0;
    result.frame_length   = announced_length;
    case (phase)
      ubxff_pkg::PH_SYNC2: begin
        if (rx_byte == ubxff_pkg::SYNC_SECOND) begin
          phase_next = ubxff_pkg::PH_CLASS;
        end else if (rx_byte == ubxff_pkg::SYNC_FIRST) begin
          phase_next = ubxff_pkg::PH_SYNC2;
        end else begin
          phase_next = ubxff_pkg::PH_HUNT;
        end
      end
      ubxff_pkg::PH_CLASS: begin
        cur_class_next = rx_byte;
        sum_a_next     = rx_byte;
        sum_b_next     = rx_byte;
        phase_next     = ubxff_pkg::PH_IDENT;
      end
      ubxff_pkg::PH_IDENT: begin
        cur_ident_next = rx_byte;
        sum_a_next     = add_a;
        sum_b_next     = add_b;
        phase_next     = ubxff_pkg::pair_enabled(cfg.accept_mask, cur_class, rx_byte)
                         ? ubxff_pkg::PH_LEN_LO : ubxff_pkg::PH_HUNT;
      end
      ubxff_pkg::PH_LEN_LO: begin
        announced_length_next = {8'd0, rx_byte};
        sum_a_next            = add_a;
        sum_b_next            = add_b;
        phase_next            = ubxff_pkg::PH_LEN_HI;
      end
      ubxff_pkg::PH_LEN_HI: begin
        announced_length_next = length_full;
        sum_a_next            = add_a;
        sum_b_next            = add_b;
        payload_count_next    = 16'd0;
        if (length_full > cfg.max_length) begin
          phase_next = ubxff_pkg::PH_HUNT;
        end else if (length_full == 16'd0) begin
          phase_next = ubxff_pkg::PH_CK_A;
        end else begin
          phase_next = ubxff_pkg::PH_PAYLOAD;
        end
      end
      ubxff_pkg::PH_PAYLOAD: begin
        sum_a_next          = add_a;
        sum_b_next          = add_b;
        emit                = 1'b1;
        result.byte_offset  = payload_count;
        result.payload_byte = rx_byte;
        payload_count_next  = count_inc;
        if (count_inc == announced_length) begin
          phase_next = ubxff_pkg::PH_CK_A;
        end
      end
      ubxff_pkg::PH_CK_A: begin
        got_check_a_next = rx_byte;
        phase_next       = ubxff_pkg::PH_CK_B;
      end
      ubxff_pkg::PH_CK_B: begin
        emit        = 1'b1;
        result.kind = (got_check_a == sum_a && rx_byte == sum_b)
                      ? ubxff_pkg::KIND_VALID : ubxff_pkg::KIND_BAD;
        phase_next  = ubxff_pkg::PH_HUNT;
      end
      default: begin
        phase_next = (rx_byte == ubxff_pkg::SYNC_FIRST)
                     ? ubxff_pkg::PH_SYNC2 : ubxff_pkg::PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= ubxff_pkg::PH_HUNT;
      cur_class        <= 8'd0;
      cur_ident        <= 8'd0;
      announced_length <= 16'd0;
      payload_count    <= 16'd0;
      sum_a            <= 8'd0;
      sum_b            <= 8'd0;
      got_check_a      <= 8'd0;
    end else if (step) begin
      phase            <= phase_next;
      cur_class        <= cur_class_next;
      cur_ident        <= cur_ident_next;
      announced_length <= announced_length_next;
      payload_count    <= payload_count_next;
      sum_a            <= sum_a_next;
      sum_b            <= sum_b_next;
      got_check_a      <= got_check_a_next;
    end
  end

endmodule

@@ src/ubx_frame_filter.sv @@
// Top level of the UBX frame filter: configuration registers and result register.
// Depends on ubxff_pkg and ubxff_parser.
//
//   channel | handshake           | payload
//   --------+---------------------+---------------------------------------------
//   rx      | rx_valid, rx_stall  | rx_byte
//   res     | res_valid,res_stall | kind, msg_class, msg_ident, byte_offset,
//           |                     | payload_byte, frame_length
//   cfg     | cfg_write           | cfg_index, cfg_data
//
// One byte is taken per cycle while not stalled; the parser state and the result
// register update on the same edge, so a byte's result appears in the next cycle.
// The single result register sets the limit: a byte is held off only while a
// result is waiting and res_stall is high.
// Reset is synchronous; it returns the parser to sync hunting and loads the
// register defaults (max_length 1024, accept_mask 31).
module ubx_frame_filter (
  input  logic        clk,
  input  logic        rst,
  input  logic        rx_valid,
  output logic        rx_stall,
  input  logic [7:0]  rx_byte,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [1:0]  kind,
  output logic [7:0]  msg_class,
  output logic [7:0]  msg_ident,
  output logic [15:0] byte_offset,
  output logic [7:0]  payload_byte,
  output logic [15:0] frame_length,
  input  logic        cfg_write,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  ubxff_pkg::cfg_t    cfg;
  ubxff_pkg::result_t result;
  ubxff_pkg::result_t held;
  logic               emit;
  logic               rx_beat;

  assign rx_stall = res_valid && res_stall;
  assign rx_beat  = rx_valid && !rx_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_length  <= ubxff_pkg::MAX_LENGTH_RESET;
      cfg.accept_mask <= ubxff_pkg::ACCEPT_MASK_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        ubxff_pkg::REG_MAX_LENGTH:  cfg.max_length  <= cfg_data;
        ubxff_pkg::REG_ACCEPT_MASK: cfg.accept_mask <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  ubxff_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (rx_beat),
    .rx_byte (rx_byte),
    .cfg     (cfg),
    .emit    (emit),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (!res_valid || !res_stall) begin
      res_valid <= rx_beat && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_beat && emit) begin
      held <= result;
    end
  end

  assign kind         = held.kind;
  assign msg_class    = held.msg_class;
  assign msg_ident    = held.msg_ident;
  assign byte_offset  = held.byte_offset;
  assign payload_byte = held.payload_byte;
  assign frame_length = held.frame_length;

  a_kind_known: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (kind == ubxff_pkg::KIND_PAYLOAD || kind == ubxff_pkg::KIND_VALID ||
                   kind == ubxff_pkg::KIND_BAD))
    else $error("result kind out of range");

  a_verdict_clean: assert property (@(posedge clk) disable iff (rst)
    (res_valid && kind != ubxff_pkg::KIND_PAYLOAD) |-> (byte_offset == 16'd0 &&
                                                         payload_byte == 8'd0))
    else $error("verdict beat carries payload data");

  a_offset_bound: assert property (@(posedge clk) disable iff (rst)
    (res_valid && kind == ubxff_pkg::KIND_PAYLOAD) |-> (byte_offset < frame_length))
    else $error("payload offset beyond announced length");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_stall) |=> ($stable(held) && res_valid))
    else $error("waiting result was overwritten or dropped");

endmodule
